/* rtl/tac_pkg.sv */
package tac_pkg;

  localparam int CAL_SAMPLES  = 20;
  localparam int CORDIC_STEPS = 16;

  localparam int SAMPLE_W = 16;
  localparam int PITCH_W  = 16;
  localparam int CNT_W    = 5;
  localparam int SUM_W    = 20;
  localparam int XW       = 27;
  localparam int ACC_W    = 26;
  localparam int STEP_W   = 5;

  localparam int HALF_TURN = 46080;
  localparam int PITCH_MAX = HALF_TURN / 2;

  localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(HALF_TURN * 128);

  // Neutral = floor((2*sum + N) / (2*N)), done on a biased, non-negative numerator
  localparam int CAL_DIV     = 2 * CAL_SAMPLES;
  localparam int CAL_U_OFS   = CAL_SAMPLES + CAL_DIV * PITCH_MAX;
  localparam int U_W         = 21;
  localparam int Q_W         = 17;
  localparam int RECIP_SHIFT = 24;
  localparam int CAL_RECIP   = (1 << RECIP_SHIFT) / CAL_DIV;

  localparam logic [1:0] OP_MEASURE  = 2'd0;
  localparam logic [1:0] OP_START    = 2'd1;
  localparam logic [1:0] OP_CONTINUE = 2'd2;

  localparam logic REG_BIAS_X = 1'b0;
  localparam logic REG_BIAS_Z = 1'b1;

  typedef struct packed {
    logic [1:0]                 opcode;
    logic signed [SAMPLE_W-1:0] tor_raw_x;
    logic signed [SAMPLE_W-1:0] tor_raw_z;
    logic signed [SAMPLE_W-1:0] lum_raw_x;
    logic signed [SAMPLE_W-1:0] lum_raw_z;
  } tac_in_t;

  typedef struct packed {
    logic signed [PITCH_W-1:0] tor_pitch;
    logic signed [PITCH_W-1:0] lum_pitch;
    logic signed [PITCH_W-1:0] tor_neutral;
    logic signed [PITCH_W-1:0] lum_neutral;
    logic                      is_calibrated;
    logic [CNT_W-1:0]          samples_taken;
  } tac_out_t;

  typedef struct packed {
    logic                      valid;
    logic [1:0]                opcode;
    logic signed [PITCH_W-1:0] tor_pitch;
    logic signed [PITCH_W-1:0] lum_pitch;
  } cal_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [PITCH_W-1:0] tor_neutral;
    logic signed [PITCH_W-1:0] lum_neutral;
    logic                      calibrated;
    logic [CNT_W-1:0]          shown;
  } cal_stat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_TOR, S_TOR_WAIT, S_LUM, S_LUM_WAIT, S_CAL_WAIT, S_PUSH
  } top_state_t;

  typedef enum logic [1:0] {
    C_IDLE, C_PREP, C_ITER, C_ROUND
  } cordic_state_t;

  typedef enum logic [1:0] {
    CL_IDLE, CL_MUL, CL_FIX, CL_DONE
  } cal_state_t;

  // atan(2^-i) in 2^-15 degree units
  function automatic logic [ACC_W-1:0] atan_lut(input logic [STEP_W-1:0] i);
    logic [ACC_W-1:0] v;
    case (i)
      5'd0:    v = ACC_W'(1474560);
      5'd1:    v = ACC_W'(870484);
      5'd2:    v = ACC_W'(459940);
      5'd3:    v = ACC_W'(233473);
      5'd4:    v = ACC_W'(117189);
      5'd5:    v = ACC_W'(58652);
      5'd6:    v = ACC_W'(29333);
      5'd7:    v = ACC_W'(14667);
      5'd8:    v = ACC_W'(7334);
      5'd9:    v = ACC_W'(3667);
      5'd10:   v = ACC_W'(1833);
      5'd11:   v = ACC_W'(917);
      5'd12:   v = ACC_W'(458);
      5'd13:   v = ACC_W'(229);
      5'd14:   v = ACC_W'(115);
      5'd15:   v = ACC_W'(57);
      5'd16:   v = ACC_W'(29);
      5'd17:   v = ACC_W'(14);
      5'd18:   v = ACC_W'(7);
      5'd19:   v = ACC_W'(4);
      5'd20:   v = ACC_W'(2);
      5'd21:   v = ACC_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tac_cordic.sv */
module tac_cordic
  import tac_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [SAMPLE_W-1:0] raw_x,
  input  logic signed [SAMPLE_W-1:0] raw_z,
  input  logic signed [SAMPLE_W-1:0] bias_x,
  input  logic signed [SAMPLE_W-1:0] bias_z,
  output logic                       done,
  output logic signed [PITCH_W-1:0]  pitch
);

  cordic_state_t state, state_next;

  logic signed [XW-1:0]    x, z;
  logic signed [XW-1:0]    ext_x, ext_z;
  logic signed [XW-1:0]    dx, dz;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] ang;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-9:0] rounded;
  logic signed [ACC_W-9:0] wrapped;
  logic [STEP_W-1:0]       step;

  assign ext_x = (XW'(raw_x) <<< 8) + XW'(bias_x);
  assign ext_z = (XW'(raw_z) <<< 8) + XW'(bias_z);
  assign dx    = z >>> step;
  assign dz    = x >>> step;
  assign ang   = $signed(atan_lut(step));

  assign acc_r   = acc + ACC_W'(128);
  assign rounded = acc_r[ACC_W-1:8];

  always_comb begin
    if (rounded <= -PITCH_MAX) begin
      wrapped = rounded + (ACC_W-8)'(HALF_TURN);
    end else if (rounded > PITCH_MAX) begin
      wrapped = rounded - (ACC_W-8)'(HALF_TURN);
    end else begin
      wrapped = rounded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      C_IDLE: begin
        if (start) begin
          x <= ext_x;
          z <= ext_z;
        end
      end
      C_PREP: begin
        step <= '0;
        if (x < 0) begin
          x   <= -x;
          z   <= -z;
          acc <= (z >= 0) ? ACC_HALF : -ACC_HALF;
        end else begin
          acc <= '0;
        end
      end
      C_ITER: begin
        step <= step + STEP_W'(1);
        if (z > 0) begin
          x   <= x + dx;
          z   <= z - dz;
          acc <= acc + ang;
        end else if (z < 0) begin
          x   <= x - dx;
          z   <= z + dz;
          acc <= acc - ang;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      C_IDLE:  if (start) state_next = C_PREP;
      C_PREP:  state_next = C_ITER;
      C_ITER:  if (step == STEP_W'(CORDIC_STEPS - 1)) state_next = C_ROUND;
      C_ROUND: state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  always_comb begin
    done  = (state == C_ROUND);
    pitch = wrapped[PITCH_W-1:0];
  end

endmodule

/* rtl/tac_calib.sv */
module tac_calib
  import tac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cal_req_t  req,
  output cal_stat_t stat
);

  cal_state_t state, state_next;

  logic signed [SUM_W-1:0]   tor_sum, lum_sum;
  logic [CNT_W-1:0]          count, shown;
  logic signed [PITCH_W-1:0] tor_neutral, lum_neutral;
  logic                      calibrated;

  logic [U_W-1:0]            tor_u, lum_u;
  logic [Q_W-1:0]            tor_q0, lum_q0;

  logic                      is_cal, restart, accum, complete;
  logic signed [SUM_W-1:0]   tor_sum_next, lum_sum_next;
  logic [CNT_W-1:0]          count_next;
  logic signed [SUM_W+2:0]   tor_uw, lum_uw;
  logic [U_W+RECIP_SHIFT-1:0] tor_prod, lum_prod;
  logic [U_W-1:0]            tor_r, lum_r;
  logic [Q_W-1:0]            tor_q, lum_q;
  logic signed [Q_W:0]       tor_nq, lum_nq;

  assign is_cal  = (req.opcode == OP_START) || (req.opcode == OP_CONTINUE);
  assign restart = (req.opcode == OP_START) ||
                   ((req.opcode == OP_CONTINUE) && (count == '0));
  assign accum   = (req.opcode == OP_CONTINUE) && (count != '0);

  always_comb begin
    if (restart) begin
      tor_sum_next = SUM_W'(req.tor_pitch);
      lum_sum_next = SUM_W'(req.lum_pitch);
      count_next   = CNT_W'(1);
    end else if (accum) begin
      tor_sum_next = tor_sum + SUM_W'(req.tor_pitch);
      lum_sum_next = lum_sum + SUM_W'(req.lum_pitch);
      count_next   = count + CNT_W'(1);
    end else begin
      tor_sum_next = tor_sum;
      lum_sum_next = lum_sum;
      count_next   = count;
    end
  end

  assign complete = is_cal && (count_next >= CNT_W'(CAL_SAMPLES));

  assign tor_uw = ((SUM_W+3)'(tor_sum_next) <<< 1) + (SUM_W+3)'(CAL_U_OFS);
  assign lum_uw = ((SUM_W+3)'(lum_sum_next) <<< 1) + (SUM_W+3)'(CAL_U_OFS);

  assign tor_prod = (U_W+RECIP_SHIFT)'(tor_u) * (U_W+RECIP_SHIFT)'(CAL_RECIP);
  assign lum_prod = (U_W+RECIP_SHIFT)'(lum_u) * (U_W+RECIP_SHIFT)'(CAL_RECIP);

  assign tor_r = tor_u - U_W'(tor_q0 * CAL_DIV);
  assign lum_r = lum_u - U_W'(lum_q0 * CAL_DIV);
  assign tor_q = (tor_r >= U_W'(CAL_DIV)) ? tor_q0 + Q_W'(1) : tor_q0;
  assign lum_q = (lum_r >= U_W'(CAL_DIV)) ? lum_q0 + Q_W'(1) : lum_q0;
  assign tor_nq = $signed({1'b0, tor_q}) - (Q_W+1)'(PITCH_MAX);
  assign lum_nq = $signed({1'b0, lum_q}) - (Q_W+1)'(PITCH_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= CL_IDLE;
      tor_sum     <= '0;
      lum_sum     <= '0;
      count       <= '0;
      shown       <= '0;
      tor_neutral <= '0;
      lum_neutral <= '0;
      calibrated  <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        CL_IDLE: begin
          if (req.valid) begin
            tor_sum <= tor_sum_next;
            lum_sum <= lum_sum_next;
            count   <= count_next;
            shown   <= count_next;
          end
        end
        CL_FIX: begin
          tor_neutral <= tor_nq[PITCH_W-1:0];
          lum_neutral <= lum_nq[PITCH_W-1:0];
          calibrated  <= 1'b1;
          tor_sum     <= '0;
          lum_sum     <= '0;
          count       <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == CL_IDLE && req.valid) begin
      tor_u <= tor_uw[U_W-1:0];
      lum_u <= lum_uw[U_W-1:0];
    end
    if (state == CL_MUL) begin
      tor_q0 <= tor_prod[RECIP_SHIFT +: Q_W];
      lum_q0 <= lum_prod[RECIP_SHIFT +: Q_W];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      CL_IDLE: begin
        if (req.valid) begin
          state_next = complete ? CL_MUL : CL_DONE;
        end
      end
      CL_MUL:  state_next = CL_FIX;
      CL_FIX:  state_next = CL_DONE;
      CL_DONE: state_next = CL_IDLE;
      default: state_next = CL_IDLE;
    endcase
  end

  always_comb begin
    stat.done        = (state == CL_DONE);
    stat.tor_neutral = tor_neutral;
    stat.lum_neutral = lum_neutral;
    stat.calibrated  = calibrated;
    stat.shown       = shown;
  end

endmodule

/* rtl/tilt_angle_calibrator_core.sv */
// Channel   Direction  Handshake                  Payload
// in        input      in_valid / in_ready        in_data  (tac_in_t)
// out       output     out_valid / out_ready      out_data (tac_out_t)
// cfg       input      cfg_wr_en                  cfg_index, cfg_data
//
// Each item passes one CORDIC unit that serves both sensors in turn, the tor
// pair first and then the lum pair, and then the calibration block, which adds
// its multiply and fix states on the item that closes a calibration run. in_ready is high only while
// no item is at work, from the edge that loads the result; a result waits in
// the output register, and a full register holds the next result back.
// Synchronous reset restores the offsets and clears all calibration state.
module tilt_angle_calibrator_core
  import tac_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  tac_in_t             in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tac_out_t            out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data
);

  top_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] bias_x, bias_z;
  tac_in_t                    item;
  logic signed [PITCH_W-1:0]  tor_pitch, lum_pitch;

  logic                       cordic_start, cordic_done;
  logic signed [SAMPLE_W-1:0] cordic_x, cordic_z;
  logic signed [PITCH_W-1:0]  cordic_pitch;
  logic                       push, slot_free;
  cal_req_t                   req;
  cal_stat_t                  stat;

  assign slot_free = !out_valid || out_ready;
  assign cordic_x  = (state == S_LUM) ? item.lum_raw_x : item.tor_raw_x;
  assign cordic_z  = (state == S_LUM) ? item.lum_raw_z : item.tor_raw_z;

  tac_cordic u_cordic (
    .clk    (clk),
    .rst    (rst),
    .start  (cordic_start),
    .raw_x  (cordic_x),
    .raw_z  (cordic_z),
    .bias_x (bias_x),
    .bias_z (bias_z),
    .done   (cordic_done),
    .pitch  (cordic_pitch)
  );

  tac_calib u_calib (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x <= SAMPLE_W'(-4952);
      bias_z <= SAMPLE_W'(-5487);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BIAS_X: bias_x <= cfg_data;
        REG_BIAS_Z: bias_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
    if (state == S_TOR_WAIT && cordic_done) begin
      tor_pitch <= cordic_pitch;
    end
    if (state == S_LUM_WAIT && cordic_done) begin
      lum_pitch <= cordic_pitch;
    end
    if (push) begin
      out_data.tor_pitch     <= tor_pitch;
      out_data.lum_pitch     <= lum_pitch;
      out_data.tor_neutral   <= stat.tor_neutral;
      out_data.lum_neutral   <= stat.lum_neutral;
      out_data.is_calibrated <= stat.calibrated;
      out_data.samples_taken <= stat.shown;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (in_valid) state_next = S_TOR;
      S_TOR:      state_next = S_TOR_WAIT;
      S_TOR_WAIT: if (cordic_done) state_next = S_LUM;
      S_LUM:      state_next = S_LUM_WAIT;
      S_LUM_WAIT: if (cordic_done) state_next = S_CAL_WAIT;
      S_CAL_WAIT: if (stat.done) state_next = S_PUSH;
      S_PUSH:     if (slot_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cordic_start  = (state == S_TOR) || (state == S_LUM);
    push          = (state == S_PUSH) && slot_free;
    req.valid     = (state == S_LUM_WAIT) && cordic_done;
    req.opcode    = item.opcode;
    req.tor_pitch = tor_pitch;
    req.lum_pitch = cordic_pitch;
  end

endmodule

/* dv/tb_tilt_angle_calibrator_core.sv */
`timescale 1ns / 100ps

module tb_tilt_angle_calibrator_core;
  import tac_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] SMAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] OFS_X_RESET = -16'sd4952;
  localparam logic signed [SAMPLE_W-1:0] OFS_Z_RESET = -16'sd5487;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT = 20000;
  localparam int TAIL_CYCLES = 60;

  // rotation angles in 2^-15 degree units
  localparam longint ROT_ANGLE [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  class tilt_scoreboard;
    tac_out_t expected_q[$];
    logic signed [SAMPLE_W-1:0] ofs_x;
    logic signed [SAMPLE_W-1:0] ofs_z;
    longint tor_sum;
    longint lum_sum;
    int run_count;
    logic signed [PITCH_W-1:0] tor_neutral;
    logic signed [PITCH_W-1:0] lum_neutral;
    logic cal_done;
    int errors;

    function new();
      ofs_x = OFS_X_RESET;
      ofs_z = OFS_Z_RESET;
      tor_sum = 0;
      lum_sum = 0;
      run_count = 0;
      tor_neutral = '0;
      lum_neutral = '0;
      cal_done = 1'b0;
      errors = 0;
    endfunction

    function void set_offset(logic idx, logic signed [SAMPLE_W-1:0] v);
      if (idx == REG_BIAS_X) ofs_x = v;
      else ofs_z = v;
    endfunction

    function longint floor_div(longint a, longint b);
      if (a >= 0) return a / b;
      return -((-a + b - 1) / b);
    endfunction

    function logic signed [PITCH_W-1:0] tilt_pitch(logic signed [SAMPLE_W-1:0] rx,
                                                   logic signed [SAMPLE_W-1:0] rz);
      longint x;
      longint z;
      longint acc;
      longint dx;
      longint dz;
      longint p;
      x = longint'(rx) * 256 + longint'(ofs_x);
      z = longint'(rz) * 256 + longint'(ofs_z);
      acc = 0;
      if (x == 0 && z == 0) return '0;
      if (x < 0) begin
        acc = (z >= 0) ? longint'(HALF_TURN) * 128 : -longint'(HALF_TURN) * 128;
        x = -x;
        z = -z;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        dx = z >>> i;
        dz = x >>> i;
        if (z > 0) begin
          x = x + dx;
          z = z - dz;
          acc = acc + ROT_ANGLE[i];
        end else if (z < 0) begin
          x = x - dx;
          z = z + dz;
          acc = acc - ROT_ANGLE[i];
        end
      end
      p = (acc + 128) >>> 8;
      if (p <= -PITCH_MAX) p = p + HALF_TURN;
      else if (p > PITCH_MAX) p = p - HALF_TURN;
      return p[PITCH_W-1:0];
    endfunction

    function void note_input(tac_in_t d);
      tac_out_t e;
      logic signed [PITCH_W-1:0] tp;
      logic signed [PITCH_W-1:0] lp;
      tp = tilt_pitch(d.tor_raw_x, d.tor_raw_z);
      lp = tilt_pitch(d.lum_raw_x, d.lum_raw_z);
      if (d.opcode == OP_START || (d.opcode == OP_CONTINUE && run_count == 0)) begin
        tor_sum = tp;
        lum_sum = lp;
        run_count = 1;
      end else if (d.opcode == OP_CONTINUE) begin
        tor_sum = tor_sum + tp;
        lum_sum = lum_sum + lp;
        run_count++;
      end
      e.samples_taken = CNT_W'(run_count);
      if ((d.opcode == OP_START || d.opcode == OP_CONTINUE) && run_count >= CAL_SAMPLES) begin
        tor_neutral = PITCH_W'(floor_div(2 * tor_sum + CAL_SAMPLES, 2 * CAL_SAMPLES));
        lum_neutral = PITCH_W'(floor_div(2 * lum_sum + CAL_SAMPLES, 2 * CAL_SAMPLES));
        cal_done = 1'b1;
        tor_sum = 0;
        lum_sum = 0;
        run_count = 0;
      end
      e.tor_pitch = tp;
      e.lum_pitch = lp;
      e.tor_neutral = tor_neutral;
      e.lum_neutral = lum_neutral;
      e.is_calibrated = cal_done;
      expected_q.push_back(e);
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(tac_out_t r);
      tac_out_t e;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("tor_pitch", e.tor_pitch, r.tor_pitch);
      compare_field("lum_pitch", e.lum_pitch, r.lum_pitch);
      compare_field("tor_neutral", e.tor_neutral, r.tor_neutral);
      compare_field("lum_neutral", e.lum_neutral, r.lum_neutral);
      compare_field("is_calibrated", e.is_calibrated, r.is_calibrated);
      compare_field("samples_taken", e.samples_taken, r.samples_taken);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  tac_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  tac_out_t out_data;
  logic cfg_wr_en = 1'b0;
  logic cfg_index = REG_BIAS_X;
  logic [SAMPLE_W-1:0] cfg_data = '0;

  tilt_scoreboard sb;
  bit hold_req = 1'b0;
  int burst_left = 0;

  tilt_angle_calibrator_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 50)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic send_fields(logic [1:0] op, logic signed [SAMPLE_W-1:0] tx,
                             logic signed [SAMPLE_W-1:0] tz, logic signed [SAMPLE_W-1:0] lx,
                             logic signed [SAMPLE_W-1:0] lz);
    tac_in_t d;
    d.opcode = op;
    d.tor_raw_x = tx;
    d.tor_raw_z = tz;
    d.lum_raw_x = lx;
    d.lum_raw_z = lz;
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_input(d);
    pace_sender();
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_raw(logic signed [SAMPLE_W-1:0] ofs);
    int s;
    case ($urandom_range(0, 5))
      0, 1: s = int'($urandom);
      2: s = int'($urandom_range(0, 8)) - 4;
      3: begin
        case ($urandom_range(0, 3))
          0: s = SMIN;
          1: s = SMAX;
          2: s = 0;
          default: s = -1;
        endcase
      end
      4: s = -(int'(ofs) >>> 8) + int'($urandom_range(0, 2)) - 1;
      default: s = int'($urandom_range(0, 4000)) - 2000;
    endcase
    return s[SAMPLE_W-1:0];
  endfunction

  task automatic send_rand(logic [1:0] op);
    send_fields(op, rand_raw(sb.ofs_x), rand_raw(sb.ofs_z), rand_raw(sb.ofs_x),
                rand_raw(sb.ofs_z));
  endtask

  task automatic wait_results_done();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  task automatic write_offsets(logic signed [SAMPLE_W-1:0] ox, logic signed [SAMPLE_W-1:0] oz);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_BIAS_X;
    cfg_data <= ox;
    @(posedge clk);
    cfg_index <= REG_BIAS_Z;
    cfg_data <= oz;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_offset(REG_BIAS_X, ox);
    sb.set_offset(REG_BIAS_Z, oz);
  endtask

  task automatic run_random(int n);
    int sent;
    int len;
    int kind;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        send_rand(OP_START);
        sent++;
        for (int k = 1; k < CAL_SAMPLES; k++) begin
          if ($urandom_range(0, 6) == 0) begin
            send_rand(($urandom_range(0, 1) == 1) ? OP_MEASURE : OP_UNUSED);
            sent++;
          end
          send_rand(OP_CONTINUE);
          sent++;
        end
      end else if (kind == 7) begin
        len = $urandom_range(1, CAL_SAMPLES - 1);
        send_rand(OP_START);
        repeat (len) send_rand(OP_CONTINUE);
        sent += len + 1;
      end else begin
        len = $urandom_range(1, 10);
        repeat (len) send_rand(2'($urandom_range(0, 3)));
        sent += len;
      end
    end
  endtask

  task automatic run_phase(logic signed [SAMPLE_W-1:0] ox, logic signed [SAMPLE_W-1:0] oz,
                           int n);
    wait_results_done();
    write_offsets(ox, oz);
    run_random(n);
  endtask

  // receiver: ready pattern independent of the sender
  initial begin
    int n;
    int k;
    int tick;
    tick = 0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0: begin
            out_ready <= 1'b1;
            repeat (n) @(posedge clk);
          end
          1: repeat (n) begin
            out_ready <= ($urandom_range(0, 1) == 1);
            @(posedge clk);
          end
          2: begin
            k = $urandom_range(2, 6);
            repeat (n) begin
              out_ready <= (tick % k == 0);
              tick++;
              @(posedge clk);
            end
          end
          default: begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
          end
        endcase
      end
    end
  end

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_fields(OP_MEASURE, SMIN, SMAX, SMAX, SMIN);
    send_fields(OP_MEASURE, 16'sd0, 16'sd0, -16'sd1, -16'sd1);

    wait_results_done();
    write_offsets(16'sd0, 16'sd0);
    send_fields(OP_MEASURE, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_fields(OP_MEASURE, 16'sd1, 16'sd0, -16'sd1, 16'sd0);
    send_fields(OP_MEASURE, 16'sd0, 16'sd1, 16'sd0, -16'sd1);
    send_fields(OP_MEASURE, SMIN, -16'sd1, SMIN, 16'sd1);
    send_fields(OP_MEASURE, SMAX, SMAX, SMIN, SMIN);
    send_fields(OP_MEASURE, SMAX, SMIN, SMIN, SMAX);
    send_fields(OP_UNUSED, 16'sd5, -16'sd3, -16'sd7, 16'sd2);
    send_fields(OP_CONTINUE, 16'sd100, 16'sd200, -16'sd300, 16'sd50);
    send_fields(OP_CONTINUE, 16'sd3, 16'sd4, 16'sd4, 16'sd3);
    send_fields(OP_MEASURE, -16'sd20, 16'sd9, 16'sd11, -16'sd40);
    send_fields(OP_START, 16'sd1, 16'sd1, -16'sd1, -16'sd1);
    send_fields(OP_CONTINUE, -16'sd8, 16'sd0, 16'sd0, 16'sd8);
    send_fields(OP_UNUSED, 16'sd0, 16'sd0, 16'sd2, 16'sd0);

    wait_results_done();
    write_offsets(SMAX, SMIN);
    send_fields(OP_MEASURE, SMIN, SMAX, 16'sd0, 16'sd0);
    send_fields(OP_MEASURE, SMAX, SMIN, -16'sd1, -16'sd1);

    run_phase(OFS_X_RESET, OFS_Z_RESET, 100);
    run_phase(16'sd0, 16'sd0, 100);
    // hold the receiver off while this phase keeps offering items
    wait_results_done();
    write_offsets(SMAX, SMAX);
    hold_req = 1'b1;
    run_random(100);
    run_phase(SMIN, SMIN, 100);
    run_phase(16'($urandom), 16'($urandom), 100);
    run_phase({8'($urandom), 8'h00}, {8'($urandom), 8'h00}, 100);
    run_phase(SMIN, SMAX, 100);

    wait_results_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
